// File: rtl/c2p_pkg.sv
package c2p_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int FRAC_BITS     = 16;
  localparam int ANGLE_WIDTH   = 16;
  localparam int QUAD_WIDTH    = 3;

  // datapath width: sign, coordinate, fraction and headroom for the cordic gain
  localparam int DATA_WIDTH = COORD_WIDTH + FRAC_BITS + 3;

  // 1/K in Q32
  localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;

  localparam logic [31:0] Z_HALF_TURN = 32'h8000_0000;

  localparam logic [ANGLE_WIDTH-1:0] ANG_ZERO    = ANGLE_WIDTH'(0);
  localparam logic [ANGLE_WIDTH-1:0] ANG_QUARTER = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
  localparam logic [ANGLE_WIDTH-1:0] ANG_HALF    = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1);
  localparam logic [ANGLE_WIDTH-1:0] ANG_3QUARTER = ANG_HALF | ANG_QUARTER;

  localparam logic [QUAD_WIDTH-1:0] QUAD_AXIS = 3'd0;
  localparam logic [QUAD_WIDTH-1:0] QUAD_1    = 3'd1;
  localparam logic [QUAD_WIDTH-1:0] QUAD_2    = 3'd2;
  localparam logic [QUAD_WIDTH-1:0] QUAD_3    = 3'd3;
  localparam logic [QUAD_WIDTH-1:0] QUAD_4    = 3'd4;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [COORD_WIDTH-1:0]        radius_t;
  typedef logic [ANGLE_WIDTH-1:0]        angle_t;
  typedef logic [QUAD_WIDTH-1:0]         quad_t;

  // atan(2^-i) as a fraction of a full turn, 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] val;
    unique case (idx)
      5'd0:  val = 32'h20000000;
      5'd1:  val = 32'h12E4051E;
      5'd2:  val = 32'h09FB385B;
      5'd3:  val = 32'h051111D4;
      5'd4:  val = 32'h028B0D43;
      5'd5:  val = 32'h0145D7E1;
      5'd6:  val = 32'h00A2F61E;
      5'd7:  val = 32'h00517C55;
      5'd8:  val = 32'h0028BE53;
      5'd9:  val = 32'h00145F2F;
      5'd10: val = 32'h000A2F98;
      5'd11: val = 32'h000517CC;
      5'd12: val = 32'h00028BE6;
      5'd13: val = 32'h000145F3;
      5'd14: val = 32'h0000A2FA;
      5'd15: val = 32'h0000517D;
      5'd16: val = 32'h000028BE;
      5'd17: val = 32'h0000145F;
      5'd18: val = 32'h00000A30;
      5'd19: val = 32'h00000518;
      5'd20: val = 32'h0000028C;
      5'd21: val = 32'h00000146;
      5'd22: val = 32'h000000A3;
      5'd23: val = 32'h00000051;
      5'd24: val = 32'h00000029;
      5'd25: val = 32'h00000014;
      5'd26: val = 32'h0000000A;
      5'd27: val = 32'h00000005;
      5'd28: val = 32'h00000003;
      5'd29: val = 32'h00000001;
      5'd30: val = 32'h00000001;
      5'd31: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

// File: rtl/c2p_if.sv
interface c2p_in_if;
  import c2p_pkg::*;

  logic   valid;
  logic   ready;
  coord_t x_coord;
  coord_t y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface c2p_out_if;
  import c2p_pkg::*;

  logic    valid;
  logic    ready;
  radius_t radius;
  angle_t  angle;
  quad_t   quadrant;

  modport source (output valid, output radius, output angle, output quadrant, input ready);
  modport sink   (input valid, input radius, input angle, input quadrant, output ready);
endinterface

// File: rtl/cartesian_to_polar_unit.sv
// cartesian to polar conversion, cordic vectoring mode
//
// in_pt (sink): one point per transfer, signed x_coord / y_coord
// out_res (source): one result per point, in order: radius (rounded, same
//   scale as the input, saturating), angle (65536 per full turn) and
//   quadrant (0 on an axis, else 1..4 counter-clockwise)
//
// pipeline: one pre-rotation stage, CORDIC_STAGES micro-rotation stages,
// one gain-multiply stage and the output register; the transfer edge loads
// the pre-rotation stage, and the point then passes through the
// micro-rotation stages, the gain-multiply stage and the output register,
// where out_res.valid rises; one point per cycle sustained while the output
// is not stalled, set by the one-iteration-per-stage cordic chain
//
// every stage has its own valid bit and loads whenever it is empty or its
// successor moves, so bubbles are squeezed out while the receiver stalls
// and in_pt.ready only drops once every stage holds a point
//
// reset (rst_n low, synchronous) empties the pipeline; no clearing time
module cartesian_to_polar_unit (
  input  logic      clk,
  input  logic      rst_n,
  c2p_in_if.sink    in_pt,
  c2p_out_if.source out_res
);
  import c2p_pkg::*;

  localparam int N    = CORDIC_STAGES;
  localparam int DW   = DATA_WIDTH;
  // split of the non-negative final x into a 32-bit low part and a high part
  localparam int HI_W = (DW - 1 > 32) ? DW - 33 : 1;
  localparam int XF_W = 32 + HI_W;
  localparam int T_W  = HI_W + 33;
  localparam logic [T_W:0] ROUND_HALF = (T_W+1)'(1) << (FRAC_BITS - 1);
  localparam logic [T_W:0] RAD_MAX    = (T_W+1)'({COORD_WIDTH{1'b1}});

  // ---------------------------------------------------------------------------
  // stage registers: index 0 is the pre-rotated point, index k is the point
  // after k micro-rotations
  // ---------------------------------------------------------------------------
  logic [N:0]                 v_r;
  logic signed [DW-1:0]       x_r    [0:N];
  logic signed [DW-1:0]       y_r    [0:N];
  logic [31:0]                z_r    [0:N];
  logic                       sp_r   [0:N];   // point on an axis or origin
  radius_t                    sprad_r[0:N];   // exact radius for axis points
  angle_t                     spang_r[0:N];   // exact angle for axis points
  quad_t                      quad_r [0:N];

  // gain multiply stage
  logic                       v_m_r;
  logic [63:0]                lo_prod_r;
  logic [HI_W+31:0]           hi_prod_r;
  logic [31:0]                z_m_r;
  logic                       sp_m_r;
  radius_t                    sprad_m_r;
  angle_t                     spang_m_r;
  quad_t                      quad_m_r;

  // output register
  logic                       out_v_r;
  radius_t                    radius_r;
  angle_t                     angle_r;
  quad_t                      quadrant_r;

  // per-stage load enables, rdy[k] loads stage k
  logic [N:0]                 rdy;
  logic                       mul_rdy;
  logic                       out_rdy;

  assign out_rdy = !out_v_r || out_res.ready;
  assign mul_rdy = !v_m_r || out_rdy;

  always_comb begin
    rdy[N] = !v_r[N] || mul_rdy;
    for (int k = N - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_pt.ready = rdy[0];

  // ---------------------------------------------------------------------------
  // input stage: quadrant, axis detection, rotation into the right half plane
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] xe, ye;
  logic signed [DW-1:0] x0_nxt, y0_nxt;
  logic [31:0]          z0_nxt;
  logic                 sp0_nxt;
  radius_t              sprad0_nxt;
  angle_t               spang0_nxt;
  quad_t                quad0_nxt;
  logic                 x_zero, y_zero, x_neg, y_neg;

  always_comb begin
    x_zero = (in_pt.x_coord == '0);
    y_zero = (in_pt.y_coord == '0);
    x_neg  = in_pt.x_coord[COORD_WIDTH-1];
    y_neg  = in_pt.y_coord[COORD_WIDTH-1];

    if (x_zero || y_zero) begin
      quad0_nxt = QUAD_AXIS;
    end else if (!x_neg) begin
      quad0_nxt = y_neg ? QUAD_4 : QUAD_1;
    end else begin
      quad0_nxt = y_neg ? QUAD_3 : QUAD_2;
    end

    sp0_nxt = x_zero || y_zero;
    priority if (x_zero && y_zero) begin
      sprad0_nxt = '0;
      spang0_nxt = ANG_ZERO;
    end else if (y_zero) begin
      sprad0_nxt = x_neg ? radius_t'(~in_pt.x_coord + 1'b1) : radius_t'(in_pt.x_coord);
      spang0_nxt = x_neg ? ANG_HALF : ANG_ZERO;
    end else begin
      sprad0_nxt = y_neg ? radius_t'(~in_pt.y_coord + 1'b1) : radius_t'(in_pt.y_coord);
      spang0_nxt = y_neg ? ANG_3QUARTER : ANG_QUARTER;
    end

    // left half plane: rotate by pi, start the angle at a half turn
    xe = DW'(in_pt.x_coord);
    ye = DW'(in_pt.y_coord);
    if (x_neg) begin
      xe = -xe;
      ye = -ye;
    end
    x0_nxt = xe <<< FRAC_BITS;
    y0_nxt = ye <<< FRAC_BITS;
    z0_nxt = x_neg ? Z_HALF_TURN : 32'h0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_r[0] <= in_pt.valid;
    end
    if (rdy[0] && in_pt.valid) begin
      x_r[0]     <= x0_nxt;
      y_r[0]     <= y0_nxt;
      z_r[0]     <= z0_nxt;
      sp_r[0]    <= sp0_nxt;
      sprad_r[0] <= sprad0_nxt;
      spang_r[0] <= spang0_nxt;
      quad_r[0]  <= quad0_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // micro-rotation stages, one iteration per stage
  // ---------------------------------------------------------------------------
  for (genvar gk = 0; gk < N; gk++) begin : g_rot
    logic signed [DW-1:0] dx, dy;
    logic signed [DW-1:0] x_nxt, y_nxt;
    logic [31:0]          z_nxt;

    always_comb begin
      // arithmetic shift is the floor shift
      dx = y_r[gk] >>> gk;
      dy = x_r[gk] >>> gk;
      if (!y_r[gk][DW-1]) begin
        x_nxt = x_r[gk] + dx;
        y_nxt = y_r[gk] - dy;
        z_nxt = z_r[gk] + atan_turn(5'(gk));
      end else begin
        x_nxt = x_r[gk] - dx;
        y_nxt = y_r[gk] + dy;
        z_nxt = z_r[gk] - atan_turn(5'(gk));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[gk+1] <= 1'b0;
      end else if (rdy[gk+1]) begin
        v_r[gk+1] <= v_r[gk];
      end
      if (rdy[gk+1] && v_r[gk]) begin
        x_r[gk+1]     <= x_nxt;
        y_r[gk+1]     <= y_nxt;
        z_r[gk+1]     <= z_nxt;
        sp_r[gk+1]    <= sp_r[gk];
        sprad_r[gk+1] <= sprad_r[gk];
        spang_r[gk+1] <= spang_r[gk];
        quad_r[gk+1]  <= quad_r[gk];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // gain removal: x * (1/K) in Q32, split into a 32x32 and a narrow product
  // ---------------------------------------------------------------------------
  logic [XF_W-1:0] xf;

  assign xf = x_r[N][DW-1] ? '0 : XF_W'(x_r[N][DW-2:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_m_r <= 1'b0;
    end else if (mul_rdy) begin
      v_m_r <= v_r[N];
    end
    if (mul_rdy && v_r[N]) begin
      lo_prod_r <= 64'(xf[31:0]) * 64'(INV_GAIN_Q32);
      hi_prod_r <= (HI_W+32)'(xf[XF_W-1:32]) * (HI_W+32)'(INV_GAIN_Q32);
      z_m_r     <= z_r[N];
      sp_m_r    <= sp_r[N];
      sprad_m_r <= sprad_r[N];
      spang_m_r <= spang_r[N];
      quad_m_r  <= quad_r[N];
    end
  end

  // ---------------------------------------------------------------------------
  // rounding, saturation and axis substitution into the output register
  // ---------------------------------------------------------------------------
  logic [T_W:0] t_sum;
  logic [T_W:0] rad_rnd;
  radius_t      radius_nxt;
  angle_t       angle_nxt;

  always_comb begin
    t_sum   = (T_W+1)'(hi_prod_r) + (T_W+1)'(lo_prod_r[63:32]);
    rad_rnd = (t_sum + ROUND_HALF) >> FRAC_BITS;
    if (sp_m_r) begin
      radius_nxt = sprad_m_r;
      angle_nxt  = spang_m_r;
    end else begin
      radius_nxt = (rad_rnd > RAD_MAX) ? radius_t'(RAD_MAX) : radius_t'(rad_rnd);
      // round half up to the top bits, wrapping a full turn to zero
      angle_nxt  = z_m_r[31:32-ANGLE_WIDTH] + angle_t'(z_m_r[31-ANGLE_WIDTH]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= v_m_r;
    end
    if (out_rdy && v_m_r) begin
      radius_r   <= radius_nxt;
      angle_r    <= angle_nxt;
      quadrant_r <= quad_m_r;
    end
  end

  assign out_res.valid    = out_v_r;
  assign out_res.radius   = radius_r;
  assign out_res.angle    = angle_r;
  assign out_res.quadrant = quadrant_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // input back-pressure only when every stage is occupied and the output stalls
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !rdy[0] |-> ((&v_r) && v_m_r && out_v_r && !out_res.ready))
    else $error("input stalled with an empty stage in the pipeline");

  // a blocked multiply stage keeps its product
  a_mul_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_m_r && !out_rdy) |=> (v_m_r && $stable(lo_prod_r) && $stable(hi_prod_r)))
    else $error("multiply stage lost or changed a stalled item");

  // axis flag and quadrant code travel together
  a_axis_quad: assert property (@(posedge clk) disable iff (!rst_n)
    v_m_r |-> (sp_m_r == (quad_m_r == QUAD_AXIS)))
    else $error("axis flag disagrees with quadrant");

  // quadrant code range at the output
  a_quad_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (quadrant_r <= QUAD_4))
    else $error("quadrant code out of range");

endmodule
